### hdl/bfteh_pkg.sv
// shared types and constants for the two-ended best-fit heap unit
package bfteh_pkg;

  localparam int unsigned RECORDS_DEF = 64;
  localparam int unsigned PAGE_BITS_DEF = 12;
  localparam int unsigned META_BYTES_DEF = 40;

  localparam int unsigned ADDR_W = 48;
  localparam int unsigned SIZE_W = 44;
  localparam int unsigned REQ_W = 32;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [1:0] REQ_ALLOC_BYTES = 2'd0;
  localparam logic [1:0] REQ_FREE_SMALL = 2'd1;
  localparam logic [1:0] REQ_ALLOC_PAGES = 2'd2;
  localparam logic [1:0] REQ_FREE_PAGES = 2'd3;

  localparam logic [2:0] ST_REUSED = 3'd0;
  localparam logic [2:0] ST_CARVED = 3'd1;
  localparam logic [2:0] ST_NOT_READY = 3'd2;
  localparam logic [2:0] ST_NO_MEMORY = 3'd3;
  localparam logic [2:0] ST_TABLE_FULL = 3'd4;
  localparam logic [2:0] ST_FREE_DONE = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_END = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_ENABLE = 2'd2;

  typedef enum logic [1:0] {
    UPD_NONE,
    UPD_USE,
    UPD_FREE,
    UPD_NEW
  } upd_op_t;

  typedef struct packed {
    upd_op_t op;
    logic kind;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
    logic [STAMP_W-1:0] stamp;
  } upd_t;

  typedef struct packed {
    logic vld;
    logic is_free;
    logic kind;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] addr;
    logic found;
    logic [SIZE_W-1:0] best_size;
    logic [STAMP_W-1:0] best_age;
    logic [ADDR_W-1:0] best_addr;
  } query_t;

endpackage

### hdl/bfteh_cell.sv
// one record cell: holds a record and refines the passing search query
module bfteh_cell #(
  parameter int unsigned IDX_W = 6,
  parameter logic [IDX_W-1:0] INDEX = '0
) (
  input  logic clk,
  input  logic rst_n,
  input  logic init,
  input  bfteh_pkg::upd_t upd,
  input  logic [IDX_W-1:0] upd_idx,
  input  logic [bfteh_pkg::STAMP_W-1:0] cur_counter,
  input  bfteh_pkg::query_t q_in,
  input  logic [IDX_W-1:0] idx_in,
  output bfteh_pkg::query_t q_out,
  output logic [IDX_W-1:0] idx_out
);
  import bfteh_pkg::*;

  logic valid_r, used_r, page_r;
  logic [ADDR_W-1:0] addr_r;
  logic [SIZE_W-1:0] size_r;
  logic [STAMP_W-1:0] stamp_r;
  query_t q_r, q_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [STAMP_W-1:0] age;
  logic fit, better, match, sel;

  always_comb begin
    age = cur_counter - stamp_r;
    fit = valid_r && !used_r && (page_r == q_in.kind) && (size_r >= q_in.size);
    better = !q_in.found || (size_r < q_in.best_size) ||
             ((size_r == q_in.best_size) && (age < q_in.best_age));
    match = valid_r && used_r && (page_r == q_in.kind) && (addr_r == q_in.addr) &&
            !q_in.found;
    sel = q_in.is_free ? match : (fit && better);
    q_nxt = q_in;
    idx_nxt = idx_in;
    if (q_in.vld && sel) begin
      q_nxt.found = 1'b1;
      q_nxt.best_size = size_r;
      q_nxt.best_age = age;
      q_nxt.best_addr = addr_r;
      idx_nxt = INDEX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || init) begin
      valid_r <= 1'b0;
      used_r <= 1'b0;
      page_r <= 1'b0;
      q_r <= '0;
      idx_r <= '0;
    end else begin
      q_r <= q_nxt;
      idx_r <= idx_nxt;
      if (upd_idx == INDEX) begin
        unique case (upd.op)
          UPD_USE: used_r <= 1'b1;
          UPD_FREE: used_r <= 1'b0;
          UPD_NEW: begin
            valid_r <= 1'b1;
            used_r <= 1'b1;
            page_r <= upd.kind;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd_idx == INDEX) begin
      if (upd.op == UPD_NEW) begin
        addr_r <= upd.addr;
        size_r <= upd.size;
        stamp_r <= '0;
      end else if (upd.op == UPD_FREE) begin
        stamp_r <= upd.stamp;
      end
    end
  end

  assign q_out = q_r;
  assign idx_out = idx_r;

`ifndef SYNTHESIS
  a_free_first: assert property (@(posedge clk) disable iff (!rst_n)
    (q_in.vld && q_in.is_free && q_in.found) |=> (idx_r == $past(idx_in)))
    else $error("free match moved past first hit");
  a_new_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (upd.op == UPD_NEW && upd_idx == INDEX && !init) |=> valid_r)
    else $error("new record not marked valid");
  a_use_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (upd.op == UPD_USE && upd_idx == INDEX) |-> valid_r)
    else $error("reuse of invalid record");
`endif
endmodule

### hdl/best_fit_two_ended_heap_unit.sv
// top level: request control, pointers, counters and the record cell chain
//
//  channel | ports                                         | direction
//  in      | in_valid in_stall in_req_type in_request_size   | request in
//          | in_free_address                                 |
//  out     | out_valid out_stall out_status out_block_address| result out
//          | out_free_matched                                |
//  cfg     | cfg_we cfg_index cfg_wdata                      | register write
//
// a search query walks the record chain one cell per cycle; a request refused
// before the search skips the chain. reset clears all records, pointers and
// counters; writing heap_enable = 1 clears records and counters, reloads pointers.
// a result waits in the output register under out_stall; the next request is
// taken meanwhile and its result waits until the register frees.
module best_fit_two_ended_heap_unit #(
  parameter int unsigned RECORDS = bfteh_pkg::RECORDS_DEF,
  parameter int unsigned PAGE_BITS = bfteh_pkg::PAGE_BITS_DEF,
  parameter int unsigned META_BYTES = bfteh_pkg::META_BYTES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] in_req_type,
  input  logic [bfteh_pkg::REQ_W-1:0] in_request_size,
  input  logic [bfteh_pkg::ADDR_W-1:0] in_free_address,
  output logic out_valid,
  input  logic out_stall,
  output logic [2:0] out_status,
  output logic [bfteh_pkg::ADDR_W-1:0] out_block_address,
  output logic out_free_matched,
  input  logic cfg_we,
  input  logic [bfteh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bfteh_pkg::ADDR_W-1:0] cfg_wdata
);
  import bfteh_pkg::*;

  localparam int unsigned IDX_W = $clog2(RECORDS);
  localparam int unsigned CNT_W = $clog2(RECORDS + 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN, S_HOLD} state_t;

  state_t state_r;
  logic [ADDR_W-1:0] pool_base_r, pool_end_r, bottom_r, top_r;
  logic heap_enable_r;
  logic [STAMP_W-1:0] counter_r;
  logic [CNT_W-1:0] count_r;
  logic [ADDR_W:0] mb_r;
  query_t launch_r, fin_r;
  logic [IDX_W-1:0] fin_idx_r;
  logic [2:0] res_status_r;
  logic [ADDR_W-1:0] res_addr_r;
  logic res_matched_r;
  logic out_valid_r;
  logic [2:0] out_status_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic out_matched_r;
  upd_t upd;
  logic [IDX_W-1:0] upd_idx;
  logic init, ready, accept, kind, oversize, no_room;
  logic [63:0] ext, rnd;
  logic [ADDR_W-1:0] gap;

  query_t q [0:RECORDS];
  logic [IDX_W-1:0] qi [0:RECORDS];

  assign init = cfg_we && (cfg_index == CFG_HEAP_ENABLE) && cfg_wdata[0];
  assign in_stall = (state_r != S_IDLE);
  assign accept = in_valid && !in_stall;
  assign kind = in_req_type[1];
  assign ready = heap_enable_r && (pool_end_r >= pool_base_r) &&
                 (pool_base_r[PAGE_BITS-1:0] == '0) && (pool_end_r[PAGE_BITS-1:0] == '0);
  assign ext = kind ? ({32'b0, in_request_size} << PAGE_BITS) : {32'b0, in_request_size};
  assign rnd = (ext + 64'd7) & ~64'd7;
  assign oversize = (rnd[63:SIZE_W] != '0);

  assign q[0] = launch_r;
  assign qi[0] = '0;

  genvar g;
  generate
    for (g = 0; g < RECORDS; g++) begin : g_cell
      bfteh_cell #(.IDX_W(IDX_W), .INDEX(IDX_W'(g))) u_cell (
        .clk(clk), .rst_n(rst_n), .init(init), .upd(upd), .upd_idx(upd_idx),
        .cur_counter(counter_r), .q_in(q[g]), .idx_in(qi[g]),
        .q_out(q[g+1]), .idx_out(qi[g+1])
      );
    end
  endgenerate

  always_comb begin
    gap = top_r - mb_r[ADDR_W-1:0];
    no_room = (mb_r > {1'b0, top_r}) || ({4'b0, fin_r.size} > gap);
    upd = '0;
    upd_idx = fin_idx_r;
    if (state_r == S_FIN) begin
      upd.kind = fin_r.kind;
      upd.size = fin_r.size;
      upd.stamp = counter_r;
      upd.addr = fin_r.kind ? (top_r - {4'b0, fin_r.size}) : mb_r[ADDR_W-1:0];
      if (fin_r.found) begin
        upd.op = fin_r.is_free ? UPD_FREE : UPD_USE;
      end else if (!fin_r.is_free && (count_r != CNT_W'(RECORDS)) && !no_room) begin
        upd.op = UPD_NEW;
        upd_idx = count_r[IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pool_base_r <= '0;
      pool_end_r <= '0;
      heap_enable_r <= 1'b0;
      bottom_r <= '0;
      top_r <= '0;
      counter_r <= '0;
      count_r <= '0;
      launch_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && (state_r != S_HOLD)) out_valid_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_POOL_BASE: pool_base_r <= cfg_wdata;
          CFG_POOL_END: pool_end_r <= cfg_wdata;
          CFG_HEAP_ENABLE: heap_enable_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (init) begin
        bottom_r <= pool_base_r;
        top_r <= pool_end_r;
        counter_r <= '0;
        count_r <= '0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            res_addr_r <= '0;
            res_matched_r <= 1'b0;
            mb_r <= {1'b0, bottom_r} + (ADDR_W + 1)'(META_BYTES);
            if (!ready) begin
              res_status_r <= ST_NOT_READY;
              state_r <= S_HOLD;
            end else if (!in_req_type[0] && oversize) begin
              res_status_r <= ST_NO_MEMORY;
              state_r <= S_HOLD;
            end else begin
              launch_r <= '{vld: 1'b1, is_free: in_req_type[0], kind: kind,
                            size: rnd[SIZE_W-1:0], addr: in_free_address,
                            found: 1'b0, best_size: '0, best_age: '0, best_addr: '0};
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          launch_r.vld <= 1'b0;
          if (q[RECORDS].vld) begin
            fin_r <= q[RECORDS];
            fin_idx_r <= qi[RECORDS];
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          state_r <= S_HOLD;
          if (fin_r.is_free) begin
            res_status_r <= ST_FREE_DONE;
            res_matched_r <= fin_r.found;
            if (fin_r.found) counter_r <= counter_r + 1'b1;
          end else if (fin_r.found) begin
            res_status_r <= ST_REUSED;
            res_addr_r <= fin_r.best_addr;
          end else if (count_r == CNT_W'(RECORDS)) begin
            res_status_r <= ST_TABLE_FULL;
          end else if (no_room) begin
            res_status_r <= ST_NO_MEMORY;
          end else begin
            res_status_r <= ST_CARVED;
            res_addr_r <= upd.addr;
            count_r <= count_r + 1'b1;
            if (fin_r.kind) begin
              top_r <= upd.addr;
              bottom_r <= mb_r[ADDR_W-1:0];
            end else begin
              bottom_r <= mb_r[ADDR_W-1:0] + {4'b0, fin_r.size};
            end
          end
        end
        S_HOLD: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_status_r <= res_status_r;
            out_addr_r <= res_addr_r;
            out_matched_r <= res_matched_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_block_address = out_addr_r;
  assign out_free_matched = out_matched_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(RECORDS))
    else $error("record count beyond table");
  a_upd_in_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (upd.op != UPD_NONE) |-> (state_r == S_FIN))
    else $error("record update outside finish");
  a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
    q[RECORDS].vld |-> (state_r == S_SCAN))
    else $error("query left chain outside scan");
  a_match_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_matched_r) |-> (out_status_r == ST_FREE_DONE))
    else $error("free match with wrong status");
`endif
endmodule

### tb/sv/best_fit_two_ended_heap_unit_checker.sv
// checker: predicts heap results from observed transfers and compares them
module best_fit_two_ended_heap_unit_checker (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_stall,
  input  logic [1:0] in_req_type,
  input  logic [bfteh_pkg::REQ_W-1:0] in_request_size,
  input  logic [bfteh_pkg::ADDR_W-1:0] in_free_address,
  input  logic out_valid,
  input  logic out_stall,
  input  logic [2:0] out_status,
  input  logic [bfteh_pkg::ADDR_W-1:0] out_block_address,
  input  logic out_free_matched,
  input  logic cfg_we,
  input  logic [bfteh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bfteh_pkg::ADDR_W-1:0] cfg_wdata,
  output int fail_count,
  output int pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import bfteh_pkg::*;

  localparam int NREC = RECORDS_DEF;
  localparam int PG = PAGE_BITS_DEF;
  localparam logic [63:0] META = 64'(META_BYTES_DEF);

  typedef struct packed {
    logic [2:0] status;
    logic [ADDR_W-1:0] addr;
    logic matched;
  } heap_result_t;

  heap_result_t awaited_results[$];

  logic [ADDR_W-1:0] base_reg, end_reg;
  logic enable_reg;
  logic [63:0] bottom_ptr, top_ptr;
  logic [ADDR_W-1:0] blk_addr [NREC];
  logic [SIZE_W-1:0] blk_size [NREC];
  logic [STAMP_W-1:0] blk_stamp [NREC];
  bit blk_valid [NREC];
  bit blk_busy [NREC];
  bit blk_page [NREC];
  logic [STAMP_W-1:0] release_ctr;
  int blk_count;

  assign pending = awaited_results.size();

  function automatic void clear_heap();
    bottom_ptr = 64'(base_reg);
    top_ptr = 64'(end_reg);
    for (int i = 0; i < NREC; i++) begin
      blk_valid[i] = 0;
      blk_busy[i] = 0;
      blk_page[i] = 0;
      blk_addr[i] = '0;
      blk_size[i] = '0;
      blk_stamp[i] = '0;
    end
    release_ctr = '0;
    blk_count = 0;
  endfunction

  function automatic heap_result_t serve_request(logic [1:0] rt, logic [REQ_W-1:0] rs,
                                                 logic [ADDR_W-1:0] fa);
    heap_result_t r;
    logic [63:0] need, mb, blk;
    logic [STAMP_W-1:0] age_i, age_b;
    logic kind;
    int best;
    bit found;
    r = '0;
    kind = rt[1];
    best = 0;
    found = 0;
    if (!enable_reg || end_reg < base_reg || base_reg[PG-1:0] != '0 ||
        end_reg[PG-1:0] != '0) begin
      r.status = ST_NOT_READY;
      return r;
    end
    if (rt == REQ_FREE_SMALL || rt == REQ_FREE_PAGES) begin
      r.status = ST_FREE_DONE;
      for (int i = 0; i < blk_count; i++) begin
        if (blk_valid[i] && blk_busy[i] && blk_page[i] == kind && blk_addr[i] == fa) begin
          blk_busy[i] = 0;
          blk_stamp[i] = release_ctr;
          release_ctr = release_ctr + 1;
          r.matched = 1;
          return r;
        end
      end
      return r;
    end
    need = kind ? (64'(rs) << PG) : 64'(rs);
    need = (need + 64'd7) & ~64'd7;
    if (need >= (64'd1 << SIZE_W)) begin
      r.status = ST_NO_MEMORY;
      return r;
    end
    for (int i = 0; i < blk_count; i++) begin
      if (!blk_valid[i] || blk_busy[i] || blk_page[i] != kind) continue;
      if (64'(blk_size[i]) < need) continue;
      if (!found || blk_size[i] < blk_size[best]) begin
        best = i;
        found = 1;
      end else if (blk_size[i] == blk_size[best]) begin
        age_i = release_ctr - blk_stamp[i];
        age_b = release_ctr - blk_stamp[best];
        if (age_i < age_b) best = i;
      end
    end
    if (found) begin
      blk_busy[best] = 1;
      r.status = ST_REUSED;
      r.addr = blk_addr[best];
      return r;
    end
    if (blk_count >= NREC) begin
      r.status = ST_TABLE_FULL;
      return r;
    end
    mb = bottom_ptr + META;
    if (mb > top_ptr || need > top_ptr - mb) begin
      r.status = ST_NO_MEMORY;
      return r;
    end
    if (kind) begin
      blk = top_ptr - need;
      top_ptr = blk;
      bottom_ptr = mb;
    end else begin
      blk = mb;
      bottom_ptr = mb + need;
    end
    blk_addr[blk_count] = blk[ADDR_W-1:0];
    blk_size[blk_count] = need[SIZE_W-1:0];
    blk_valid[blk_count] = 1;
    blk_busy[blk_count] = 1;
    blk_page[blk_count] = kind;
    blk_stamp[blk_count] = '0;
    blk_count++;
    r.status = ST_CARVED;
    r.addr = blk[ADDR_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    heap_result_t exp_r;
    if (!rst_n) begin
      base_reg = '0;
      end_reg = '0;
      enable_reg = 0;
      clear_heap();
      awaited_results.delete();
      fail_count <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10)
            $display("[%0t] unexpected result transfer: status %0d addr %h", $realtime,
                     out_status, out_block_address);
        end else begin
          exp_r = awaited_results.pop_front();
          if (out_status !== exp_r.status || out_block_address !== exp_r.addr ||
              out_free_matched !== exp_r.matched) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("[%0t] result mismatch: expected status %0d addr %h matched %0d,",
                       $realtime, exp_r.status, exp_r.addr, exp_r.matched,
                       " got status %0d addr %h matched %0d", out_status,
                       out_block_address, out_free_matched);
          end
        end
      end
      if (in_valid && !in_stall)
        awaited_results.push_back(serve_request(in_req_type, in_request_size,
                                                in_free_address));
      if (cfg_we) begin
        case (cfg_index)
          CFG_POOL_BASE: base_reg = cfg_wdata;
          CFG_POOL_END: end_reg = cfg_wdata;
          CFG_HEAP_ENABLE: begin
            enable_reg = cfg_wdata[0];
            if (cfg_wdata[0]) clear_heap();
          end
          default: ;
        endcase
      end
    end
  end

endmodule

### tb/sv/best_fit_two_ended_heap_unit_tb.sv
// testbench top: request stimulus, result stalls, configuration phases and verdict
module best_fit_two_ended_heap_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bfteh_pkg::*;

  localparam int LIMIT = 800000;
  localparam logic [ADDR_W-1:0] TOP_PAGE = 48'hFFFF_FFFF_F000;

  logic clk, rst_n;
  logic in_valid, in_stall;
  logic [1:0] in_req_type;
  logic [REQ_W-1:0] in_request_size;
  logic [ADDR_W-1:0] in_free_address;
  logic out_valid, out_stall;
  logic [2:0] out_status;
  logic [ADDR_W-1:0] out_block_address;
  logic out_free_matched;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ADDR_W-1:0] cfg_wdata;
  int fail_count, pending;

  int cycles, sent, received, carved, reused, refused;
  bit hold_request;
  logic [1:0] sent_types[$];
  logic [ADDR_W-1:0] small_blocks[$], page_runs[$];

  best_fit_two_ended_heap_unit dut (.*);

  best_fit_two_ended_heap_unit_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result side: track returned blocks so frees can target them
  always @(posedge clk) begin
    logic [1:0] rt;
    if (rst_n && out_valid && !out_stall && sent_types.size() > 0) begin
      rt = sent_types.pop_front();
      received <= received + 1;
      if (out_status == ST_CARVED) carved <= carved + 1;
      if (out_status == ST_REUSED) reused <= reused + 1;
      if (out_status == ST_NO_MEMORY || out_status == ST_TABLE_FULL ||
          out_status == ST_NOT_READY) refused <= refused + 1;
      if (out_status == ST_CARVED || out_status == ST_REUSED) begin
        if (rt == REQ_ALLOC_PAGES) page_runs.push_back(out_block_address);
        else small_blocks.push_back(out_block_address);
      end
    end
  end

  initial begin
    int n, taken;
    out_stall = 1;
    taken = 0;
    @(posedge clk);
    wait (rst_n);
    forever begin
      if (hold_request) begin
        hold_request = 0;
        out_stall <= 1;
        repeat (900) @(posedge clk);
      end
      n = ((taken / 41) % 3 == 0) ? 0 : $urandom_range(0, 14);
      if (n > 0) begin
        out_stall <= 1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 0;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  task automatic send(logic [1:0] rt, logic [REQ_W-1:0] rs, logic [ADDR_W-1:0] fa);
    int n;
    n = ((sent / 37) % 3 == 0) ? 0 : $urandom_range(0, 14);
    if (n > 0) begin
      in_valid <= 0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1;
    in_req_type <= rt;
    in_request_size <= rs;
    in_free_address <= fa;
    do @(posedge clk); while (in_stall);
    sent_types.push_back(rt);
    sent++;
  endtask

  task automatic settle();
    in_valid <= 0;
    @(posedge clk);
    while (received != sent) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic new_region(logic [ADDR_W-1:0] b, logic [ADDR_W-1:0] e);
    cfg_write(CFG_POOL_BASE, b);
    cfg_write(CFG_POOL_END, e);
    cfg_write(CFG_HEAP_ENABLE, 1);
    small_blocks.delete();
    page_runs.delete();
  endtask

  function automatic logic [ADDR_W-1:0] rand_addr();
    return {16'($urandom), 32'($urandom)};
  endfunction

  task automatic random_traffic(int count);
    int r;
    logic [ADDR_W-1:0] a;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 33)
        send(REQ_ALLOC_BYTES, ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 300),
             rand_addr());
      else if (r < 50)
        send(REQ_ALLOC_PAGES, ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 4),
             rand_addr());
      else if (r < 70 && small_blocks.size() > 0)
        send(REQ_FREE_SMALL, $urandom,
             small_blocks[$urandom_range(0, small_blocks.size() - 1)]);
      else if (r < 85 && page_runs.size() > 0)
        send(REQ_FREE_PAGES, $urandom, page_runs[$urandom_range(0, page_runs.size() - 1)]);
      else if (r < 92 && small_blocks.size() > 0) begin
        a = small_blocks[$urandom_range(0, small_blocks.size() - 1)];
        send(REQ_FREE_PAGES, $urandom, a);
      end else
        send(2'($urandom_range(0, 3)), $urandom, rand_addr());
    end
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_req_type = REQ_ALLOC_BYTES;
    in_request_size = '0;
    in_free_address = '0;
    cfg_we = 0;
    cfg_index = CFG_POOL_BASE;
    cfg_wdata = '0;
    cycles = 0;
    sent = 0;
    received = 0;
    carved = 0;
    reused = 0;
    refused = 0;
    hold_request = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // disabled and badly shaped regions
    send(REQ_ALLOC_BYTES, 16, '0);
    send(REQ_FREE_SMALL, 0, '0);
    settle();
    cfg_write(CFG_POOL_BASE, 48'h1001);
    cfg_write(CFG_POOL_END, 48'h8000);
    cfg_write(CFG_HEAP_ENABLE, 1);
    send(REQ_ALLOC_BYTES, 8, '0);
    settle();
    new_region(48'h9000, 48'h2000);
    send(REQ_ALLOC_PAGES, 1, '0);
    settle();

    // small region: carve, free, reuse, recency, exhaustion
    new_region(48'h2000, 48'h6000);
    send(REQ_ALLOC_BYTES, 0, '0);
    send(REQ_ALLOC_BYTES, 1, '0);
    send(REQ_ALLOC_BYTES, 16, '0);
    send(REQ_ALLOC_BYTES, 16, '0);
    send(REQ_ALLOC_PAGES, 1, '0);
    send(REQ_ALLOC_PAGES, 0, '0);
    settle();
    send(REQ_FREE_SMALL, 0, small_blocks[2]);
    send(REQ_FREE_SMALL, 0, small_blocks[3]);
    send(REQ_FREE_SMALL, 0, small_blocks[3]);
    send(REQ_FREE_PAGES, 0, small_blocks[1]);
    send(REQ_FREE_PAGES, 0, page_runs[0]);
    send(REQ_ALLOC_BYTES, 9, '0);
    send(REQ_ALLOC_PAGES, 1, '0);
    send(REQ_ALLOC_PAGES, 32'hFFFF_FFFF, '0);
    send(REQ_ALLOC_BYTES, 32'hFFFF_FFFF, '0);
    send(REQ_FREE_SMALL, 0, 48'hFFFF_FFFF_FFFF);
    send(REQ_ALLOC_PAGES, 8, '0);
    settle();

    // region at the very top: nothing fits
    new_region(TOP_PAGE, TOP_PAGE);
    send(REQ_ALLOC_BYTES, 0, '0);
    send(REQ_ALLOC_PAGES, 0, '0);
    settle();

    // random phases; first one with a long output hold-off
    new_region(48'h10000, 48'h50000);
    hold_request = 1;
    random_traffic(260);
    settle();
    new_region('0, TOP_PAGE);
    random_traffic(220);
    settle();
    new_region(48'h3000, 48'h5000);
    random_traffic(160);
    settle();
    cfg_write(CFG_POOL_END, 48'h7_0000);
    random_traffic(60);
    settle();
    cfg_write(CFG_POOL_END, 48'h7_0800);
    random_traffic(40);
    settle();
    new_region(48'hA000_0000_0000, 48'hA000_0010_0000);
    random_traffic(120);
    settle();
    cfg_write(CFG_HEAP_ENABLE, 0);
    random_traffic(20);
    settle();

    $display("covered %0d requests over several regions: %0d carved, %0d reused,",
             sent, carved, reused, " %0d refused (not ready, out of memory, table full)",
             refused);
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/bfteh_pkg.sv
hdl/bfteh_cell.sv
hdl/best_fit_two_ended_heap_unit.sv
tb/sv/best_fit_two_ended_heap_unit_checker.sv
tb/sv/best_fit_two_ended_heap_unit_tb.sv
